>>> src/b2s_pkg.sv
// Shared types, constants and control struct for the BLAKE2s compression core.
package b2s_pkg;

  localparam int WORD_W  = 32;
  localparam int IN_TD_W = 168;
  localparam int OUT_TD_W = 256;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
      4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
      4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3},
    '{4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
      4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4},
    '{4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
      4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8},
    '{4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
      4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13},
    '{4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
      4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9},
    '{4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
      4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11},
    '{4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
      4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10},
    '{4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
      4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5},
    '{4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
      4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0}
  };

  localparam logic [3:0] LAST_WORD = 4'd15;
  localparam logic       MODE_LOAD = 1'b0;
  localparam logic       MODE_STORE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_RUN,
    ST_FOLD,
    ST_OUT
  } state_t;

  // Row rotation applied to the working matrix after a mix step.
  typedef enum logic [1:0] {
    PERM_NONE,
    PERM_ROT,
    PERM_DIAG,
    PERM_UNDIAG
  } perm_t;

  typedef struct packed {
    logic       in_ready;
    logic       out_valid;
    logic       mix_en;
    logic       half;
    perm_t      perm;
    logic       fold;
    logic [3:0] rd_addr;
  } ctrl_t;

endpackage

>>> src/blake2s_compress_core.sv
// Top level of the BLAKE2s compression core: state, message store and datapath.
//
// Input stream (in_*): one beat per 32-bit word. in_tuser is the mode bit:
// 0 loads chaining word word_index (0..7, higher indexes are dropped), 1
// stores message word word_index. Storing word 15 starts a compression using
// the counter and finalization words carried in the same beat.
// in_tready stays high while idle.
// A compression runs from the word 15 beat to out_tvalid through a message
// prefetch state, the mixing of ROUND_COUNT rounds on the single mixing unit
// doing one half of G per cycle, and a fold state. in_tready is low from that
// beat until the result beat is taken.
// Output stream (out_*): one beat holding the eight new chaining words. If
// the receiver stalls, the beat and the chaining value hold, and no input is
// accepted until out_tready.
// Reset clears the chaining value to zero and returns to idle. Message words
// must be written before a compression reads them.
module blake2s_compress_core #(
  parameter int ROUND_COUNT = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [3:0] word_index, [35:4] word_value, [67:36] counter_low,
  // [99:68] counter_high, [131:100] final_block_flag,
  // [163:132] final_node_flag, [167:164] zero
  input  logic [b2s_pkg::IN_TD_W-1:0]    in_tdata,
  // [0] mode
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] hash_word_0 ... [255:224] hash_word_7
  output logic [b2s_pkg::OUT_TD_W-1:0]   out_tdata
);

  b2s_pkg::ctrl_t ctrl;
  b2s_pkg::word_t cv_r [8];
  b2s_pkg::word_t v_r [16];
  b2s_pkg::word_t v_mix [16];
  b2s_pkg::word_t v_nxt [16];
  b2s_pkg::word_t msg_mem [16];
  b2s_pkg::word_t mdata_r;
  b2s_pkg::word_t g_a, g_b, g_c, g_d;
  logic [1:0]     rot_amt [4];

  logic           in_beat;
  logic           start;
  logic [3:0]     word_index;
  b2s_pkg::word_t word_value;
  b2s_pkg::word_t counter_low;
  b2s_pkg::word_t counter_high;
  b2s_pkg::word_t final_block_flag;
  b2s_pkg::word_t final_node_flag;

  assign word_index       = in_tdata[3:0];
  assign word_value       = in_tdata[35:4];
  assign counter_low      = in_tdata[67:36];
  assign counter_high     = in_tdata[99:68];
  assign final_block_flag = in_tdata[131:100];
  assign final_node_flag  = in_tdata[163:132];

  assign in_beat = in_tvalid && in_tready;
  assign start   = in_beat && (in_tuser == b2s_pkg::MODE_STORE) &&
                   (word_index == b2s_pkg::LAST_WORD);

  b2s_seq #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .out_tready(out_tready),
    .ctrl      (ctrl)
  );

  assign in_tready  = ctrl.in_ready;
  assign out_tvalid = ctrl.out_valid;

  // Message store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_beat && (in_tuser == b2s_pkg::MODE_STORE)) begin
      msg_mem[word_index] <= word_value;
    end
    mdata_r <= msg_mem[ctrl.rd_addr];
  end

  // The unit always works on column 0 of the 4x4 working matrix.
  b2s_g_unit u_g (
    .a_i   (v_r[0]),
    .b_i   (v_r[4]),
    .c_i   (v_r[8]),
    .d_i   (v_r[12]),
    .x_i   (mdata_r),
    .half_i(ctrl.half),
    .a_o   (g_a),
    .b_o   (g_b),
    .c_o   (g_c),
    .d_o   (g_d)
  );

  // Per-row left rotation: plain steps move the next column to position 0,
  // the diag/undiag codes fold in the diagonal shuffle as well.
  always_comb begin
    rot_amt = '{2'd0, 2'd0, 2'd0, 2'd0};
    case (ctrl.perm)
      b2s_pkg::PERM_ROT:    rot_amt = '{2'd1, 2'd1, 2'd1, 2'd1};
      b2s_pkg::PERM_DIAG:   rot_amt = '{2'd1, 2'd2, 2'd3, 2'd0};
      b2s_pkg::PERM_UNDIAG: rot_amt = '{2'd1, 2'd0, 2'd3, 2'd2};
      default:              rot_amt = '{2'd0, 2'd0, 2'd0, 2'd0};
    endcase
  end

  always_comb begin
    v_mix     = v_r;
    v_mix[0]  = g_a;
    v_mix[4]  = g_b;
    v_mix[8]  = g_c;
    v_mix[12] = g_d;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        v_nxt[4*r + c] = v_mix[{2'(r), 2'(c) + rot_amt[r]}];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= cv_r[i];
      end
      for (int i = 0; i < 4; i++) begin
        v_r[8 + i] <= b2s_pkg::IV[i];
      end
      v_r[12] <= b2s_pkg::IV[4] ^ counter_low;
      v_r[13] <= b2s_pkg::IV[5] ^ counter_high;
      v_r[14] <= b2s_pkg::IV[6] ^ final_block_flag;
      v_r[15] <= b2s_pkg::IV[7] ^ final_node_flag;
    end else if (ctrl.mix_en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= '0;
      end
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= cv_r[i] ^ v_r[i] ^ v_r[i + 8];
      end
    end else if (in_beat && (in_tuser == b2s_pkg::MODE_LOAD) && !word_index[3]) begin
      cv_r[word_index[2:0]] <= word_value;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      out_tdata[32*i +: 32] = cv_r[i];
    end
  end

endmodule

>>> src/b2s_g_unit.sv
// Shared half-G mixing unit: one add/xor/rotate half of the G function per cycle.
module b2s_g_unit (
  input  b2s_pkg::word_t a_i,
  input  b2s_pkg::word_t b_i,
  input  b2s_pkg::word_t c_i,
  input  b2s_pkg::word_t d_i,
  input  b2s_pkg::word_t x_i,
  input  logic           half_i,
  output b2s_pkg::word_t a_o,
  output b2s_pkg::word_t b_o,
  output b2s_pkg::word_t c_o,
  output b2s_pkg::word_t d_o
);

  b2s_pkg::word_t dx;
  b2s_pkg::word_t bx;

  assign a_o = a_i + b_i + x_i;
  assign dx  = d_i ^ a_o;
  // first half rotates by 16 and 12, second half by 8 and 7
  assign d_o = half_i ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
  assign c_o = c_i + d_o;
  assign bx  = b_i ^ c_o;
  assign b_o = half_i ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};

endmodule

>>> src/b2s_seq.sv
// Round/step sequencer for the compression core.
module b2s_seq #(
  parameter int ROUND_COUNT = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           out_tready,
  output b2s_pkg::ctrl_t ctrl
);

  localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

  b2s_pkg::state_t state_r, state_nxt;
  logic [RW-1:0]   round_r, round_nxt;
  logic [3:0]      step_r, step_nxt;
  logic [RW-1:0]   round_inc;
  logic [2:0]      g_idx;

  assign round_inc = (round_r == LAST_ROUND) ? '0 : round_r + 1'b1;
  assign g_idx     = step_r[3:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2s_pkg::ST_IDLE;
      round_r <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    step_nxt  = step_r;
    ctrl      = '{in_ready: 1'b0, out_valid: 1'b0, mix_en: 1'b0, half: 1'b0,
                  perm: b2s_pkg::PERM_NONE, fold: 1'b0, rd_addr: 4'd0};
    unique case (state_r)
      b2s_pkg::ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (start) begin
          state_nxt = b2s_pkg::ST_PRE;
          round_nxt = '0;
          step_nxt  = '0;
        end
      end
      b2s_pkg::ST_PRE: begin
        // prefetch first message word of round 0
        ctrl.rd_addr = b2s_pkg::SIGMA[0][0];
        state_nxt    = b2s_pkg::ST_RUN;
      end
      b2s_pkg::ST_RUN: begin
        ctrl.mix_en = 1'b1;
        ctrl.half   = step_r[0];
        if (step_r[0]) begin
          if (g_idx == 3'd3) begin
            ctrl.perm = b2s_pkg::PERM_DIAG;
          end else if (g_idx == 3'd7) begin
            ctrl.perm = b2s_pkg::PERM_UNDIAG;
          end else begin
            ctrl.perm = b2s_pkg::PERM_ROT;
          end
        end
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd15) begin
          ctrl.rd_addr = b2s_pkg::SIGMA[4'(round_inc)][0];
          round_nxt    = round_inc;
          if (round_r == LAST_ROUND) begin
            state_nxt = b2s_pkg::ST_FOLD;
          end
        end else begin
          ctrl.rd_addr = b2s_pkg::SIGMA[4'(round_r)][step_r + 4'd1];
        end
      end
      b2s_pkg::ST_FOLD: begin
        ctrl.fold = 1'b1;
        state_nxt = b2s_pkg::ST_OUT;
      end
      b2s_pkg::ST_OUT: begin
        ctrl.out_valid = 1'b1;
        if (out_tready) begin
          state_nxt = b2s_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = b2s_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/b2s_checker.sv
// Port-level checks for the compression core, bound to the top level.
module b2s_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [b2s_pkg::IN_TD_W-1:0]  in_tdata,
  input logic                         in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [b2s_pkg::OUT_TD_W-1:0] out_tdata
);

  logic in_beat;
  logic start_beat;

  assign in_beat    = in_tvalid && in_tready;
  assign start_beat = in_beat && (in_tuser == b2s_pkg::MODE_STORE) &&
                      (in_tdata[3:0] == b2s_pkg::LAST_WORD);

  // input side is closed while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("in_tready high while result beat pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed under stall");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_beat |=> !in_tready && !out_tvalid)
    else $error("core not busy after word 15 beat");

  a_word_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && !start_beat |=> in_tready && !out_tvalid)
    else $error("plain word beat stalled input or made a result");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready && !out_tvalid)
    else $error("core not idle after result beat");

endmodule

bind blake2s_compress_core b2s_checker u_b2s_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the BLAKE2s compression core, one word per input beat.
module testbench;

  localparam int ROUNDS      = 10;
  localparam int CHAIN_WORDS = 8;
  localparam int MSG_WORDS   = 16;
  localparam int LATENCY     = 16 * ROUNDS + 2;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int MAX_REPORTS = 10;
  localparam b2s_pkg::word_t ALL_ONES = 32'hFFFF_FFFF;
  // word i sits at [32*i +: 32]
  localparam logic [255:0] IV_WORDS = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [b2s_pkg::IN_TD_W-1:0]  in_tdata;
  logic                         in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [b2s_pkg::OUT_TD_W-1:0] out_tdata;

  // predictor state
  b2s_pkg::word_t               chain_h [CHAIN_WORDS];
  b2s_pkg::word_t               msg_m [MSG_WORDS];
  logic [MSG_WORDS-1:0]         msg_written = '0;
  logic [b2s_pkg::OUT_TD_W-1:0] hash_expect [$];

  int words_sent  = 0;
  int fail_count  = 0;
  int cycle_count = 0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;

  blake2s_compress_core #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[blake2s_compress_core] ERROR");
      $finish;
    end
  end

  // Message schedule row r, entry j in nibble j.
  function automatic logic [63:0] sched_row(input int r);
    case (r)
      0: return 64'hFEDCBA9876543210;
      1: return 64'h357B20C16DF984AE;
      2: return 64'h491763EADF250C8B;
      3: return 64'h8F04A562EBCD1397;
      4: return 64'hD386CB1EFA427509;
      5: return 64'h91EF57D438B0A6C2;
      6: return 64'hB8293670A4DEF15C;
      7: return 64'hA2684F05931CE7BD;
      8: return 64'h5A417D2C803B9EF6;
      default: return 64'h0DC3E9BF5167482A;
    endcase
  endfunction

  function automatic b2s_pkg::word_t rotr32(input b2s_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Runs the rounds on the current chain and message, folds into chain_h.
  function automatic logic [b2s_pkg::OUT_TD_W-1:0] compress_block(
    input b2s_pkg::word_t tlo, input b2s_pkg::word_t thi,
    input b2s_pkg::word_t f0, input b2s_pkg::word_t f1);
    b2s_pkg::word_t               v [16];
    logic [63:0]                  order;
    logic [b2s_pkg::OUT_TD_W-1:0] digest;
    b2s_pkg::word_t               x;
    b2s_pkg::word_t               y;
    int                           i;
    int                           r;
    int                           g;
    int                           k;
    int                           a;
    int                           b;
    int                           c;
    int                           d;
    for (i = 0; i < 8; i++) begin
      v[i]     = chain_h[i];
      v[i + 8] = IV_WORDS[32*i +: 32];
    end
    v[12] ^= tlo;
    v[13] ^= thi;
    v[14] ^= f0;
    v[15] ^= f1;
    for (r = 0; r < ROUNDS; r++) begin
      order = sched_row(r % 10);
      for (g = 0; g < 8; g++) begin
        // first four steps mix columns, last four mix diagonals
        k = g % 4;
        a = k;
        b = (g < 4) ? 4 + k : 4 + (k + 1) % 4;
        c = (g < 4) ? 8 + k : 8 + (k + 2) % 4;
        d = (g < 4) ? 12 + k : 12 + (k + 3) % 4;
        x = msg_m[order[8*g +: 4]];
        y = msg_m[order[8*g + 4 +: 4]];
        v[a] = v[a] + v[b] + x;
        v[d] = rotr32(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr32(v[b] ^ v[c], 12);
        v[a] = v[a] + v[b] + y;
        v[d] = rotr32(v[d] ^ v[a], 8);
        v[c] = v[c] + v[d];
        v[b] = rotr32(v[b] ^ v[c], 7);
      end
    end
    for (i = 0; i < 8; i++) begin
      chain_h[i] ^= v[i] ^ v[i + 8];
      digest[32*i +: 32] = chain_h[i];
    end
    return digest;
  endfunction

  function automatic int pick_gap(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, longest);
  endfunction

  function automatic b2s_pkg::word_t pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    if (r == 2) return b2s_pkg::word_t'(1) << $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic b2s_pkg::word_t pick_flag();
    int r;
    r = $urandom_range(0, 3);
    if (r == 1) return ALL_ONES;
    if (r == 2) return $urandom;
    return '0;
  endfunction

  function automatic bit last_store_ok();
    return &msg_written[MSG_WORDS-2:0];
  endfunction

  // Drives one beat and updates the predictor once it is taken.
  task automatic send_word(input logic mode, input logic [3:0] idx,
                           input b2s_pkg::word_t val, input b2s_pkg::word_t clo,
                           input b2s_pkg::word_t chi, input b2s_pkg::word_t fb,
                           input b2s_pkg::word_t fn);
    int gap;
    gap = tx_burst ? 0 : pick_gap(40);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, fn, fb, chi, clo, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode == b2s_pkg::MODE_LOAD) begin
      if (idx < CHAIN_WORDS) begin
        chain_h[idx[2:0]] = val;
        words_sent++;
      end
    end else begin
      msg_m[idx]       = val;
      msg_written[idx] = 1'b1;
      words_sent++;
      if (idx == b2s_pkg::LAST_WORD) hash_expect.push_back(compress_block(clo, chi, fb, fn));
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    idle_input();
    while (hash_expect.size() != 0) @(posedge clk);
  endtask

  // One message block: optional chain loads, words 0..14 (or some of them), then word 15.
  task automatic random_block();
    int         order [MSG_WORDS-1];
    int         n_loads;
    int         n_msg;
    int         i;
    int         j;
    int         tmp;
    if ($urandom_range(0, 1)) begin
      n_loads = $urandom_range(1, CHAIN_WORDS);
      for (i = 0; i < n_loads; i++)
        send_word(b2s_pkg::MODE_LOAD,
                  (n_loads == CHAIN_WORDS) ? 4'(i) : 4'($urandom_range(0, 7)),
                  pick_word(), $urandom, $urandom, $urandom, $urandom);
    end
    for (i = 0; i < MSG_WORDS - 1; i++) order[i] = i;
    if ($urandom_range(0, 2) == 0) begin
      for (i = MSG_WORDS - 2; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    // once words 0..14 are all written, some blocks refresh only 0 to 14 of them
    n_msg = (last_store_ok() && $urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 15;
    for (i = 0; i < n_msg; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_word(b2s_pkg::MODE_LOAD, 4'($urandom_range(8, 15)), $urandom, $urandom,
                  $urandom, $urandom, $urandom);
      send_word(b2s_pkg::MODE_STORE, 4'(order[i]), pick_word(), $urandom, $urandom,
                $urandom, $urandom);
    end
    send_word(b2s_pkg::MODE_STORE, b2s_pkg::LAST_WORD, pick_word(), pick_word(),
              pick_word(), pick_flag(), pick_flag());
  endtask

  task automatic random_noise(input int count);
    logic       mode;
    logic [3:0] idx;
    int         i;
    for (i = 0; i < count; i++) begin
      mode = 1'($urandom_range(0, 1));
      idx  = 4'($urandom_range(0, 15));
      if (mode == b2s_pkg::MODE_STORE && idx == b2s_pkg::LAST_WORD && !last_store_ok())
        idx = b2s_pkg::LAST_WORD - 4'd1;
      send_word(mode, idx, pick_word(), pick_word(), pick_word(), pick_flag(), pick_flag());
    end
  endtask

  // From reset the chain is zero; message words at extremes mixed with random ones, counter and flags all ones.
  task automatic test_first_block();
    b2s_pkg::word_t val;
    int             i;
    for (i = 0; i < MSG_WORDS - 1; i++) begin
      case (i % 4)
        0:       val = '0;
        1:       val = ALL_ONES;
        2:       val = 32'h8000_0001;
        default: val = $urandom;
      endcase
      send_word(b2s_pkg::MODE_STORE, 4'(i), val, $urandom, $urandom, $urandom, $urandom);
    end
    send_word(b2s_pkg::MODE_STORE, b2s_pkg::LAST_WORD, ALL_ONES, ALL_ONES, ALL_ONES,
              ALL_ONES, ALL_ONES);
  endtask

  // Chain loads at both ends, loads past the chain that must be dropped, zero counter.
  task automatic test_chain_loads();
    send_word(b2s_pkg::MODE_LOAD, 4'd0, '0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_word(b2s_pkg::MODE_LOAD, 4'd7, ALL_ONES, $urandom, $urandom, $urandom, $urandom);
    send_word(b2s_pkg::MODE_LOAD, 4'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_word(b2s_pkg::MODE_LOAD, 4'd8, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_word(b2s_pkg::MODE_LOAD, 4'd15, ALL_ONES, $urandom, $urandom, $urandom, $urandom);
    send_word(b2s_pkg::MODE_STORE, b2s_pkg::LAST_WORD, '0, '0, '0, '0, '0);
  endtask

  task automatic test_random_blocks(input int target);
    int kind;
    while (words_sent < target) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      kind     = $urandom_range(0, 9);
      if (kind < 7) random_block();
      else if (kind < 9) random_noise($urandom_range(1, 6));
      else drain_results();
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Sender waits for every digest, then a block goes in back to back.
  task automatic test_drain_pause();
    drain_results();
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    random_block();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin : rx_stall
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = rx_burst ? 0 : pick_gap(60);
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic [b2s_pkg::OUT_TD_W-1:0] want;
    int                           i;
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_expect.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected output beat: %h", out_tdata);
      end else begin
        want = hash_expect.pop_front();
        for (i = 0; i < CHAIN_WORDS; i++) begin
          if (out_tdata[32*i +: 32] !== want[32*i +: 32]) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("hash_word_%0d mismatch: expected %08h, actual %08h", i,
                       want[32*i +: 32], out_tdata[32*i +: 32]);
          end
        end
      end
    end
  end

  initial begin : main_seq
    int i;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    for (i = 0; i < CHAIN_WORDS; i++) chain_h[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_block();
    test_chain_loads();
    test_random_blocks(1050);
    test_drain_pause();

    drain_results();
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && hash_expect.size() == 0) begin
      $display("[blake2s_compress_core] OK");
    end else begin
      $display("[blake2s_compress_core] ERROR");
    end
    $finish;
  end

endmodule
